>>> sv/chm_pkg.sv
package chm_pkg;

  typedef logic [2:0]  event_t;
  typedef logic [4:0]  row_t;
  typedef logic [5:0]  half_t;
  typedef logic [8:0]  dur_t;
  typedef logic [12:0] samp_idx_t;
  typedef logic [2:0]  note_idx_t;
  typedef logic [13:0] peak_t;
  typedef logic [6:0]  ramp_t;
  typedef logic [20:0] prod_t;
  typedef logic [6:0]  volume_t;

  // Envelope ramp length in samples; 80 = 16 * 5, so the divide is a shift and a divide by 5.
  localparam ramp_t              RampSamples    = 7'd80;
  localparam int unsigned        RampShift      = 4;
  localparam logic [16:0]        RecipFive      = 17'd104858;  // ceil(2^19 / 5)
  localparam int unsigned        RecipFiveShift = 19;

  // Peak level = floor(min(volume, 100) * 32767 / 200), done as (x >> 3) / 25.
  localparam volume_t            VolumeMax         = 7'd100;
  localparam volume_t            VolumeReset       = 7'd60;
  localparam peak_t              PeakReset         = 14'd9830;
  localparam logic [19:0]        RecipTwentyFive   = 20'd671089;  // ceil(2^24 / 25)
  localparam int unsigned        RecipTwentyFiveSh = 24;

  typedef enum logic {
    REG_ENABLE = 1'b0,
    REG_VOLUME = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Registered middle stage between the sequencer and the envelope scaler.
  typedef struct packed {
    logic  valid;
    logic  active;
    logic  accepted;
    logic  neg;
    prod_t prod;
  } stage_t;

  typedef struct packed {
    logic signed [14:0] sample;
    logic               active;
    logic               accepted;
  } beat_t;

  // Half period in samples of each note row at 16 kHz; zero marks a rest.
  function automatic half_t note_half(row_t row);
    half_t h;
    case (row)
      5'd0:    h = 6'd15;
      5'd1:    h = 6'd12;
      5'd2:    h = 6'd10;
      5'd3:    h = 6'd15;
      5'd4:    h = 6'd12;
      5'd5:    h = 6'd10;
      5'd6:    h = 6'd7;
      5'd7:    h = 6'd0;
      5'd8:    h = 6'd10;
      5'd9:    h = 6'd7;
      5'd10:   h = 6'd36;
      5'd11:   h = 6'd0;
      5'd12:   h = 6'd36;
      5'd13:   h = 6'd0;
      5'd14:   h = 6'd48;
      5'd15:   h = 6'd8;
      5'd16:   h = 6'd12;
      5'd17:   h = 6'd0;
      5'd18:   h = 6'd12;
      5'd19:   h = 6'd10;
      5'd20:   h = 6'd8;
      5'd21:   h = 6'd10;
      5'd22:   h = 6'd8;
      5'd23:   h = 6'd13;
      5'd24:   h = 6'd0;
      5'd25:   h = 6'd10;
      5'd26:   h = 6'd4;
      default: h = 6'd0;
    endcase
    return h;
  endfunction

  // Note duration in milliseconds.
  function automatic dur_t note_dur(row_t row);
    dur_t d;
    case (row)
      5'd0:    d = 9'd90;
      5'd1:    d = 9'd90;
      5'd2:    d = 9'd140;
      5'd3:    d = 9'd110;
      5'd4:    d = 9'd110;
      5'd5:    d = 9'd110;
      5'd6:    d = 9'd220;
      5'd7:    d = 9'd80;
      5'd8:    d = 9'd90;
      5'd9:    d = 9'd320;
      5'd10:   d = 9'd220;
      5'd11:   d = 9'd80;
      5'd12:   d = 9'd220;
      5'd13:   d = 9'd80;
      5'd14:   d = 9'd360;
      5'd15:   d = 9'd80;
      5'd16:   d = 9'd100;
      5'd17:   d = 9'd60;
      5'd18:   d = 9'd100;
      5'd19:   d = 9'd110;
      5'd20:   d = 9'd110;
      5'd21:   d = 9'd110;
      5'd22:   d = 9'd200;
      5'd23:   d = 9'd60;
      5'd24:   d = 9'd40;
      5'd25:   d = 9'd90;
      5'd26:   d = 9'd8;
      default: d = 9'd8;
    endcase
    return d;
  endfunction

  // Note length in samples: 16 samples per millisecond at 16 kHz.
  function automatic samp_idx_t note_total(row_t row);
    return {note_dur(row), 4'b0000};
  endfunction

  function automatic row_t mel_start(event_t ev);
    row_t r;
    case (ev)
      3'd0:    r = 5'd0;
      3'd1:    r = 5'd3;
      3'd2:    r = 5'd10;
      3'd3:    r = 5'd15;
      3'd4:    r = 5'd16;
      3'd5:    r = 5'd19;
      3'd6:    r = 5'd23;
      3'd7:    r = 5'd26;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic note_idx_t mel_len(event_t ev);
    note_idx_t n;
    case (ev)
      3'd0:    n = 3'd3;
      3'd1:    n = 3'd7;
      3'd2:    n = 3'd5;
      3'd3:    n = 3'd1;
      3'd4:    n = 3'd3;
      3'd5:    n = 3'd4;
      3'd6:    n = 3'd3;
      3'd7:    n = 3'd1;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic peak_t peak_from_volume(volume_t v);
    volume_t     vc;
    logic [21:0] x;
    logic [18:0] y;
    logic [38:0] p;
    vc = (v > VolumeMax) ? VolumeMax : v;
    x  = {vc, 15'b0} - 22'(vc);
    y  = x[21:3];
    p  = 39'(y) * 39'(RecipTwentyFive);
    return peak_t'(p >> RecipTwentyFiveSh);
  endfunction

endpackage

>>> sv/chm_event_fifo.sv
module chm_event_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  chm_pkg::fifo_ctl_t  ctl_i,
  input  chm_pkg::event_t     wdata_i,
  output chm_pkg::event_t     rdata_o,
  output chm_pkg::fifo_stat_t stat_o
);
  import chm_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  event_t          mem_q [Depth];
  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (count_q == FullCnt);
  assign stat_o.empty = (count_q == '0);
  assign do_push      = ctl_i.push && !stat_o.full;
  assign do_pop       = ctl_i.pop && !stat_o.empty;
  assign rdata_o      = mem_q[head_q];

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (do_push) begin
      tail_d = (tail_q == LastPtr) ? '0 : tail_q + 1'b1;
    end
    if (do_pop) begin
      head_d = (head_q == LastPtr) ? '0 : head_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Entries carry no reset; they are only read behind the fill count.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[tail_q] <= wdata_i;
    end
  end

endmodule

>>> sv/chm_note_seq.sv
module chm_note_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic                in_valid_i,
  input  logic                mode_i,
  input  logic                enable_i,
  input  chm_pkg::peak_t      vol_peak_i,
  input  chm_pkg::event_t     head_i,
  input  chm_pkg::fifo_stat_t fifo_stat_i,
  output chm_pkg::fifo_ctl_t  fifo_ctl_o,
  output chm_pkg::stage_t     stage_o
);
  import chm_pkg::*;

  logic      playing_q, playing_d;
  event_t    event_q, event_d;
  note_idx_t note_q, note_d;
  samp_idx_t sidx_q, sidx_d;
  half_t     phase_q, phase_d;
  logic      wave_q, wave_d;
  peak_t     peak_q, peak_d;
  stage_t    stage_q, stage_d;

  logic      tick, play, start;
  logic      playing_e, wave_e;
  event_t    ev_e;
  note_idx_t note_e;
  samp_idx_t sidx_e, total;
  half_t     phase_e, half;
  peak_t     peak_e;
  row_t      row;
  note_idx_t len;
  logic      sounding;
  ramp_t     ramp;
  prod_t     prod;

  assign tick  = in_valid_i && !mode_i;
  assign play  = in_valid_i && mode_i;
  assign fifo_ctl_o.push = play && enable_i && !fifo_stat_i.full;
  assign fifo_ctl_o.pop  = tick && !playing_q && !fifo_stat_i.empty;
  // A popped event starts a melody only when enabled; otherwise it is discarded.
  assign start = fifo_ctl_o.pop && enable_i;

  // State as seen by this tick, including a melody that starts right now.
  assign playing_e = playing_q || start;
  assign ev_e      = start ? head_i     : event_q;
  assign note_e    = start ? '0         : note_q;
  assign sidx_e    = start ? '0         : sidx_q;
  assign phase_e   = start ? '0         : phase_q;
  assign wave_e    = start ? 1'b1       : wave_q;
  assign peak_e    = start ? vol_peak_i : peak_q;

  assign row      = mel_start(ev_e) + row_t'(note_e);
  assign half     = note_half(row);
  assign total    = note_total(row);
  assign len      = mel_len(ev_e);
  assign sounding = (half != '0) && (peak_e != '0);

  // Envelope weight out of RampSamples: rising ramp, falling ramp, or full.
  always_comb begin
    if (sidx_e < samp_idx_t'(RampSamples)) begin
      ramp = sidx_e[6:0];
    end else if ((14'(sidx_e) + 14'(RampSamples)) > 14'(total)) begin
      ramp = ramp_t'(total - sidx_e);
    end else begin
      ramp = RampSamples;
    end
  end

  assign prod = prod_t'(peak_e) * prod_t'(ramp);

  always_comb begin
    playing_d = playing_q;
    event_d   = event_q;
    note_d    = note_q;
    sidx_d    = sidx_q;
    phase_d   = phase_q;
    wave_d    = wave_q;
    peak_d    = peak_q;
    if (tick) begin
      playing_d = playing_e;
      event_d   = ev_e;
      note_d    = note_e;
      sidx_d    = sidx_e;
      phase_d   = phase_e;
      wave_d    = wave_e;
      peak_d    = peak_e;
      if (playing_e) begin
        if (sounding) begin
          if (({1'b0, phase_e} + 7'd1) >= {1'b0, half}) begin
            phase_d = '0;
            wave_d  = !wave_e;
          end else begin
            phase_d = phase_e + 1'b1;
          end
        end
        if ((14'(sidx_e) + 14'd1) >= 14'(total)) begin
          sidx_d  = '0;
          phase_d = '0;
          wave_d  = 1'b1;
          if (({1'b0, note_e} + 4'd1) >= {1'b0, len}) begin
            note_d    = '0;
            playing_d = 1'b0;
          end else begin
            note_d = note_e + 1'b1;
          end
        end else begin
          sidx_d = sidx_e + 1'b1;
        end
      end
    end
  end

  always_comb begin
    stage_d.valid    = in_valid_i;
    stage_d.active   = tick && playing_e;
    stage_d.accepted = fifo_ctl_o.push;
    stage_d.neg      = !wave_e;
    stage_d.prod     = (tick && playing_e && sounding) ? prod : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q <= 1'b0;
      event_q   <= '0;
      note_q    <= '0;
      sidx_q    <= '0;
      phase_q   <= '0;
      wave_q    <= 1'b1;
      peak_q    <= '0;
      stage_q   <= '0;
    end else begin
      playing_q <= playing_d;
      event_q   <= event_d;
      note_q    <= note_d;
      sidx_q    <= sidx_d;
      phase_q   <= phase_d;
      wave_q    <= wave_d;
      peak_q    <= peak_d;
      if (advance_i) begin
        stage_q <= stage_d;
      end
    end
  end

  assign stage_o = stage_q;

endmodule

>>> sv/chm_env_scale.sv
module chm_env_scale (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  chm_pkg::stage_t stage_i,
  output logic            valid_o,
  output chm_pkg::beat_t  beat_o
);
  import chm_pkg::*;

  logic [16:0] scaled;
  logic [33:0] recip_prod;
  peak_t       mag;
  beat_t       beat_d, beat_q;
  logic        valid_q;

  // floor(prod / 80) = floor((prod >> 4) / 5), the divide by 5 by reciprocal.
  assign scaled     = stage_i.prod[20:RampShift];
  assign recip_prod = 34'(scaled) * 34'(RecipFive);
  assign mag        = peak_t'(recip_prod >> RecipFiveShift);

  always_comb begin
    beat_d.sample   = stage_i.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    beat_d.active   = stage_i.active;
    beat_d.accepted = stage_i.accepted;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

>>> sv/chime_melody_tone_generator_top.sv
// Chime melody tone generator: square-wave melodies with a linear attack/release envelope.
// Input stream: each beat is either a sample tick (s_axis_tuser = 0) or a play request
// (s_axis_tuser = 1) whose event id in s_axis_tdata names one of eight stock melodies.
// A play request queues the id in a small event FIFO when the block is enabled and the
// FIFO has room. On a tick an idle block pops the oldest event and, if enabled, starts its melody.
// Output stream: exactly one beat per input beat, in order, carrying the audio sample,
// an active flag and, for play requests, whether the event was queued.
// The sequencer and envelope weight are evaluated into a middle stage register, and the
// divide-by-80 envelope scaling is evaluated into the output register. Throughput is one
// beat per cycle while the receiver does not stall.
// When the receiver stalls, the whole two-stage pipeline holds and s_axis_tready drops in
// the same cycle; no beat is lost or repeated.
// Reset clears the FIFO fill count, the melody state and both pipeline valid bits, and sets
// enable to 1 and volume to 60. The APB port writes enable (address 0) and volume
// (address 4); both are meant to be written only while the block is idle.
module chime_melody_tone_generator_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [2:0] event_id, [7:3] zero
  input  logic [0:0]  s_axis_tuser,   // [0] mode
  // Master stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [14:0] sample, [15] zero
  output logic [1:0]  m_axis_tuser,   // [0] active, [1] accepted
  // APB configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import chm_pkg::*;

  logic       enable_q;
  volume_t    volume_q;
  peak_t      vol_peak_q;
  logic       cfg_write;
  reg_idx_e   cfg_idx;

  logic       advance;
  logic       in_accept;
  fifo_ctl_t  fifo_ctl;
  fifo_stat_t fifo_stat;
  event_t     fifo_head;
  stage_t     stage;
  beat_t      beat;
  logic       out_valid;

  // Configuration registers. The peak level for the written volume is worked out at
  // write time so that a melody start only has to copy it.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b1;
      volume_q   <= VolumeReset;
      vol_peak_q <= PeakReset;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_ENABLE: enable_q <= pwdata[0];
        REG_VOLUME: begin
          volume_q   <= pwdata[6:0];
          vol_peak_q <= peak_from_volume(pwdata[6:0]);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ENABLE: prdata = {31'b0, enable_q};
      REG_VOLUME: prdata = {25'b0, volume_q};
      default:    prdata = '0;
    endcase
  end

  // The pipeline moves whenever the output register is empty or being drained.
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  chm_event_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (fifo_ctl),
    .wdata_i (s_axis_tdata[2:0]),
    .rdata_o (fifo_head),
    .stat_o  (fifo_stat)
  );

  chm_note_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .in_valid_i  (in_accept),
    .mode_i      (s_axis_tuser[0]),
    .enable_i    (enable_q),
    .vol_peak_i  (vol_peak_q),
    .head_i      (fifo_head),
    .fifo_stat_i (fifo_stat),
    .fifo_ctl_o  (fifo_ctl),
    .stage_o     (stage)
  );

  chm_env_scale u_env (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .stage_i   (stage),
    .valid_o   (out_valid),
    .beat_o    (beat)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, beat.sample};
  assign m_axis_tuser  = {beat.accepted, beat.active};

  // A stalled output must hold the input side off in the same cycle.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while output is stalled");

  // The FIFO never takes a push while full.
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_stat.full |-> !fifo_ctl.push)
    else $error("event pushed into a full FIFO");

  // A beat outside a melody carries a silent sample.
  a_idle_is_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 16'd0))
    else $error("nonzero sample outside a melody");

  // A queued play request never reports an active sample.
  a_accept_not_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> !m_axis_tuser[0])
    else $error("play beat marked active");

endmodule

>>> tb/chime_tone_tb_pkg.sv
package chime_tone_tb_pkg;

  // Meaning of the single tuser bit on the input stream.
  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_PLAY = 1'b1
  } beat_kind_e;

endpackage

>>> tb/chime_tone_checker.sv
module chime_tone_checker
  import chm_pkg::*;
  import chime_tone_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_data_i,   // [2:0] event_id, [7:3] zero
  input  logic [0:0]  in_user_i,   // [0] mode
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] out_data_i,  // [14:0] sample, [15] zero
  input  logic [1:0]  out_user_i,  // [0] active, [1] accepted
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          fail_count_o,
  output int          pending_o,
  output logic        quiet_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned SampleRate  = 16000;
  localparam int unsigned MsPerSecond = 1000;
  localparam int unsigned RampLen     = 80;
  localparam int unsigned VolumeCap   = 100;
  localparam int unsigned FullScale   = 32767;
  localparam int unsigned PeakDivisor = 200;
  localparam int          MaxReports  = 50;

  // Note table: frequency in Hz (zero is a rest) and duration in ms, melody by melody.
  localparam int unsigned NoteFreq [27] = '{
    523, 659, 784,
    523, 659, 784, 1047, 0, 784, 1047,
    220, 0, 220, 0, 165,
    1000,
    659, 0, 659,
    784, 988, 784, 988,
    600, 0, 800,
    2000};
  localparam int unsigned NoteMs [27] = '{
    90, 90, 140,
    110, 110, 110, 220, 80, 90, 320,
    220, 80, 220, 80, 360,
    80,
    100, 60, 100,
    110, 110, 110, 200,
    60, 40, 90,
    8};
  localparam int unsigned MelFirst [8] = '{0, 3, 10, 15, 16, 19, 23, 26};
  localparam int unsigned MelNotes [8] = '{3, 7, 5, 1, 3, 4, 3, 1};

  logic        tone_en;
  volume_t     tone_vol;
  event_t      queued_events[$];
  logic        playing;
  event_t      cur_ev;
  int unsigned note_idx;
  int unsigned samp_idx;
  int unsigned phase;
  logic        wave_hi;
  int unsigned peak;
  beat_t       pending_tones[$];
  int          fails;

  // Advances the tone state by one input beat and returns the beat it must produce.
  function automatic beat_t predict_tone(beat_kind_e kind, event_t ev);
    beat_t       r;
    event_t      popped;
    int unsigned vol;
    int unsigned row;
    int unsigned freq;
    int unsigned total;
    int unsigned half;
    int unsigned mag;
    r = '0;
    if (kind == KIND_PLAY) begin
      if (tone_en && queued_events.size() < QueueDepth) begin
        queued_events.push_back(ev);
        r.accepted = 1'b1;
      end
    end else begin
      if (!playing && queued_events.size() > 0) begin
        popped = queued_events.pop_front();
        if (tone_en) begin
          vol      = (tone_vol > VolumeCap) ? VolumeCap : tone_vol;
          peak     = vol * FullScale / PeakDivisor;
          cur_ev   = popped;
          note_idx = 0;
          samp_idx = 0;
          phase    = 0;
          wave_hi  = 1'b1;
          playing  = 1'b1;
        end
      end
      if (playing) begin
        r.active = 1'b1;
        row   = MelFirst[cur_ev] + note_idx;
        freq  = NoteFreq[row];
        total = SampleRate * NoteMs[row] / MsPerSecond;
        if (total < 1) begin
          total = 1;
        end
        half = (freq != 0) ? SampleRate / (2 * freq) : 0;
        if (freq != 0 && peak != 0 && half != 0) begin
          mag = peak;
          if (samp_idx < RampLen) begin
            mag = mag * samp_idx / RampLen;
          end else if (samp_idx + RampLen > total) begin
            mag = mag * (total - samp_idx) / RampLen;
          end
          r.sample = wave_hi ? 15'(mag) : 15'(-int'(mag));
          phase++;
          if (phase >= half) begin
            phase   = 0;
            wave_hi = ~wave_hi;
          end
        end
        samp_idx++;
        if (samp_idx >= total) begin
          samp_idx = 0;
          phase    = 0;
          wave_hi  = 1'b1;
          note_idx++;
          if (note_idx >= MelNotes[cur_ev]) begin
            note_idx = 0;
            playing  = 1'b0;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, int want, int got);
    fails++;
    if (fails <= MaxReports) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    beat_t want;
    beat_t got;
    if (!rst_ni) begin
      tone_en  = 1'b1;
      tone_vol = VolumeReset;
      queued_events.delete();
      pending_tones.delete();
      playing  = 1'b0;
      cur_ev   = '0;
      note_idx = 0;
      samp_idx = 0;
      phase    = 0;
      wave_hi  = 1'b1;
      peak     = 0;
      fails    = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      quiet_o      <= 1'b1;
    end else begin
      // Outputs first: a beat leaving now can never belong to a beat entering now.
      if (out_valid_i && out_ready_i) begin
        got.sample   = out_data_i[14:0];
        got.active   = out_user_i[0];
        got.accepted = out_user_i[1];
        if (pending_tones.size() == 0) begin
          fails++;
          if (fails <= MaxReports) begin
            $error("unexpected output beat: sample %0d active %0b accepted %0b",
                   got.sample, got.active, got.accepted);
          end
        end else begin
          want = pending_tones.pop_front();
          if (got.sample !== want.sample) begin
            report_mismatch("sample", int'(want.sample), int'(got.sample));
          end
          if (got.active !== want.active) begin
            report_mismatch("active", int'(want.active), int'(got.active));
          end
          if (got.accepted !== want.accepted) begin
            report_mismatch("accepted", int'(want.accepted), int'(got.accepted));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        pending_tones.push_back(predict_tone(beat_kind_e'(in_user_i[0]), in_data_i[2:0]));
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[2]))
          REG_ENABLE: tone_en  = pwdata_i[0];
          REG_VOLUME: tone_vol = pwdata_i[6:0];
          default: ;
        endcase
      end
      fail_count_o <= fails;
      pending_o    <= pending_tones.size();
      quiet_o      <= !playing && queued_events.size() == 0;
    end
  end

endmodule

>>> tb/chime_melody_tone_generator_top_test.sv
module chime_melody_tone_generator_top_test
  import chm_pkg::*;
  import chime_tone_tb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // The watchdog limit covers the long receiver hold-off plus the longest sender gap,
  // with a wide margin; any correct run keeps beats moving far more often than this.
  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned LongHold   = 200;
  localparam int unsigned TailCycles = 8;
  localparam int unsigned PhaseBeats = 125;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int   fail_count;
  int   pending;
  logic quiet;
  int   idle_cycles = 0;

  // Calm turns off all random idling on both streams; a hold request asks the
  // receiver for one long stall so the pipeline backs up into the input.
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  chime_melody_tone_generator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // The checker watches both streams and the register port, predicts every output
  // beat and compares it; it reports its failure count, the number of beats still
  // owed, and whether the melody engine is quiet (nothing playing, nothing queued).
  chime_tone_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_user_i   (m_axis_tuser),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .quiet_o      (quiet)
  );

  // Count cycles in which no beat moves on either stream.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("** chime_melody_tone_generator_top: FAILED **");
    $finish;
  end

  // Receiver: ready most of the time, with random stall bursts, and one long stall
  // on request so that the block fills and stalls its input.
  initial begin : receiver
    int stall;
    stall = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = LongHold;
      end else if (stall == 0 && !calm && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 12);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offers one beat, sometimes after a random gap, and returns at the edge where
  // it is taken. Valid stays high so that back-to-back beats need no toggle.
  task automatic send_beat(input beat_kind_e kind, input event_t ev);
    int gap;
    if (!calm && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b00000, ev};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // A tick carries a random event id, which the block must ignore.
  task automatic tick();
    send_beat(KIND_TICK, event_t'($urandom_range(0, 7)));
  endtask

  task automatic play(input event_t ev);
    send_beat(KIND_PLAY, ev);
  endtask

  // Stops offering beats and waits until every predicted beat has come out.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Keeps ticking until the current melody and everything queued behind it is done.
  task automatic drain();
    settle();
    while (!quiet) tick();
    settle();
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // The two longest melodies run for over fifteen thousand samples, so they are
  // picked less often; the remap keeps every id bit toggling.
  function automatic event_t pick_event();
    event_t ev;
    ev = event_t'($urandom_range(0, 7));
    if ((ev == 3'd1 || ev == 3'd2) && $urandom_range(0, 1) == 1) begin
      ev = ev ^ 3'b100;
    end
    return ev;
  endfunction

  // One setting of the registers: a burst of requests to start melodies, then a
  // mix dominated by ticks, and finally a pause until every beat is out. Melodies
  // still playing or queued carry over into the next phase.
  task automatic random_phase(input logic en, input volume_t vol, input bit squeeze);
    int unsigned lead;
    int unsigned k;
    write_reg(REG_ENABLE, {31'b0, en});
    write_reg(REG_VOLUME, {25'b0, vol});
    if (squeeze) begin
      hold_req = 1'b1;
    end
    lead = $urandom_range(1, 4);
    for (k = 0; k < PhaseBeats; k++) begin
      if (k < lead || $urandom_range(0, 99) < 12) begin
        play(pick_event());
      end else begin
        tick();
      end
    end
    settle();
  endtask

  initial begin : stimulus
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KIND_TICK;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: a tick with nothing queued, then the queue is filled past its
    // depth so the last request is dropped, and a request after a pop fits again.
    tick();
    play(3'd7);
    play(3'd3);
    play(3'd4);
    play(3'd6);
    play(3'd2);
    tick();
    tick();
    play(3'd1);
    settle();

    // Once the block is disabled, the click already playing runs to its end and the
    // events still queued are popped and thrown away; a request while disabled is
    // dropped.
    write_reg(REG_ENABLE, 32'd0);
    drain();
    play(3'd2);
    tick();
    settle();

    // Random phases across the register range: full volume, the smallest nonzero
    // volume under a long output stall, volumes above the cap, a disabled phase,
    // silence at zero volume, and a final phase without any idling.
    random_phase(1'b1, 7'd100, 1'b0);
    random_phase(1'b1, 7'd1, 1'b1);
    random_phase(1'b1, 7'd127, 1'b0);
    random_phase(1'b0, 7'd80, 1'b0);
    random_phase(1'b1, 7'd0, 1'b0);
    random_phase(1'b1, volume_t'($urandom_range(0, 127)), 1'b0);
    random_phase(1'b1, 7'd99, 1'b0);
    calm = 1'b1;
    random_phase(1'b1, volume_t'($urandom_range(0, 127)), 1'b0);

    // Everything is out; give a stray extra beat a chance to show up.
    settle();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** chime_melody_tone_generator_top: PASSED **");
    end else begin
      $display("** chime_melody_tone_generator_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/chm_pkg.sv
sv/chm_event_fifo.sv
sv/chm_note_seq.sv
sv/chm_env_scale.sv
sv/chime_melody_tone_generator_top.sv
tb/chime_tone_tb_pkg.sv
tb/chime_tone_checker.sv
tb/chime_melody_tone_generator_top_test.sv
